// File: hdl/rab_pkg.sv
// shared types, constants and helpers for the rectangle alpha blend fill
`default_nettype none
package rab_pkg;

  localparam int unsigned MAX_FRAME_DIM_DEF = 4096;

  localparam int unsigned REG_W      = 13;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned LANES      = 3;
  localparam int unsigned PROD_W     = 16;
  localparam int unsigned DEN_W      = 16;
  localparam int unsigned NUM_W      = 24;
  localparam int unsigned QUO_W      = 8;

  localparam logic [REG_W-1:0] FRAME_DIM_RST = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILL_COLOR   = 3'd0,
    REG_RECT_LEFT    = 3'd1,
    REG_RECT_TOP     = 3'd2,
    REG_RECT_RIGHT   = 3'd3,
    REG_RECT_BOTTOM  = 3'd4,
    REG_FRAME_WIDTH  = 3'd5,
    REG_FRAME_HEIGHT = 3'd6
  } cfg_reg_t;

  // clipped rectangle, start inclusive and end exclusive
  typedef struct packed {
    logic [REG_W-1:0] x_lo;
    logic [REG_W-1:0] x_hi;
    logic [REG_W-1:0] y_lo;
    logic [REG_W-1:0] y_hi;
  } bounds_t;

  // word carried down the divider stages, lane 0 is blue, lane 2 is red
  typedef struct packed {
    logic                              hit;
    logic [COLOR_W-1:0]                dst;
    logic [DEN_W-1:0]                  den;
    logic [LANES-1:0][NUM_W-1:0]       rem;
    logic [LANES-1:0][QUO_W-1:0]       quo;
  } div_word_t;

  // floor(d / 255) for d below 255 * 256
  function automatic logic [CH_W-1:0] div255(input logic [DEN_W-1:0] d);
    logic [DEN_W:0] s;
    s = {1'b0, d} + (DEN_W+1)'(1) + {{(DEN_W-CH_W+1){1'b0}}, d[DEN_W-1:CH_W]};
    return s[DEN_W-1:CH_W];
  endfunction

endpackage
`default_nettype wire

// File: hdl/rab_cfg.sv
// configuration registers and the registered clipped rectangle bounds
`default_nettype none
module rab_cfg #(
  parameter int unsigned MAX_FRAME_DIM = rab_pkg::MAX_FRAME_DIM_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [rab_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rab_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic      [rab_pkg::COLOR_W-1:0]      fill_color,
  output rab_pkg::bounds_t                      bounds
);
  import rab_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_FRAME_DIM + 1);
  localparam int unsigned LIM_W = (REG_W > DIM_W) ? REG_W : DIM_W;
  localparam logic [LIM_W-1:0] DIM_LIMIT = LIM_W'(MAX_FRAME_DIM);

  logic [REG_W-1:0] rect_left;
  logic [REG_W-1:0] rect_top;
  logic [REG_W-1:0] rect_right;
  logic [REG_W-1:0] rect_bottom;
  logic [REG_W-1:0] frame_width;
  logic [REG_W-1:0] frame_height;
  bounds_t          bounds_next;

  // ordered edges, end clipped to the frame and the frame to the limit
  function automatic logic [2*REG_W-1:0] span(input logic [REG_W-1:0] e0,
                                               input logic [REG_W-1:0] e1,
                                               input logic [REG_W-1:0] frame);
    logic [REG_W-1:0] lo;
    logic [REG_W-1:0] hi_e;
    logic [LIM_W-1:0] lim;
    logic [LIM_W-1:0] hi_w;
    lo   = (e0 < e1) ? e0 : e1;
    hi_e = (e0 > e1) ? e0 : e1;
    lim  = (LIM_W'(frame) > DIM_LIMIT) ? DIM_LIMIT : LIM_W'(frame);
    hi_w = (LIM_W'(hi_e) < lim) ? LIM_W'(hi_e) : lim;
    return {lo, hi_w[REG_W-1:0]};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_color   <= '0;
      rect_left    <= '0;
      rect_top     <= '0;
      rect_right   <= '0;
      rect_bottom  <= '0;
      frame_width  <= FRAME_DIM_RST;
      frame_height <= FRAME_DIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILL_COLOR:   fill_color   <= cfg_data[COLOR_W-1:0];
        REG_RECT_LEFT:    rect_left    <= cfg_data[REG_W-1:0];
        REG_RECT_TOP:     rect_top     <= cfg_data[REG_W-1:0];
        REG_RECT_RIGHT:   rect_right   <= cfg_data[REG_W-1:0];
        REG_RECT_BOTTOM:  rect_bottom  <= cfg_data[REG_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[REG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    {bounds_next.x_lo, bounds_next.x_hi} = span(rect_left, rect_right, frame_width);
    {bounds_next.y_lo, bounds_next.y_hi} = span(rect_top, rect_bottom, frame_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds <= '0;
    end else begin
      bounds <= bounds_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/rab_front.sv
// input register, rectangle test and the blend products ahead of the divider
`default_nettype none
module rab_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [rab_pkg::POS_W-1:0]     pos_x,
  input  wire logic [rab_pkg::POS_W-1:0]     pos_y,
  input  wire logic [rab_pkg::COLOR_W-1:0]   dst_pixel,
  input  wire logic [rab_pkg::COLOR_W-1:0]   fill_color,
  input  rab_pkg::bounds_t                   bounds,
  output logic                               out_valid,
  output rab_pkg::div_word_t                 out_word
);
  import rab_pkg::*;

  // stage a: captured transfer
  logic               a_valid;
  logic [POS_W-1:0]   a_x;
  logic [POS_W-1:0]   a_y;
  logic [COLOR_W-1:0] a_dst;

  // stage b: 8x8 products
  logic                          b_valid;
  logic                          b_inside;
  logic [COLOR_W-1:0]            b_dst;
  logic [PROD_W-1:0]             b_ta255;
  logic [PROD_W-1:0]             b_wb;
  logic [LANES-1:0][PROD_W-1:0]  b_tcta;

  logic [CH_W-1:0]               ta;
  logic [CH_W-1:0]               ba;
  logic                          inside_next;
  logic [PROD_W-1:0]             wb_next;
  logic [PROD_W-1:0]             ta255_next;
  logic [LANES-1:0][PROD_W-1:0]  tcta_next;
  div_word_t                     word_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x   <= pos_x;
      a_y   <= pos_y;
      a_dst <= dst_pixel;
    end
  end

  always_comb begin
    ta          = fill_color[COLOR_W-1 -: CH_W];
    ba          = a_dst[COLOR_W-1 -: CH_W];
    inside_next = ({1'b0, a_x} >= bounds.x_lo) && ({1'b0, a_x} < bounds.x_hi) &&
                  ({1'b0, a_y} >= bounds.y_lo) && ({1'b0, a_y} < bounds.y_hi);
    wb_next     = ba * (8'd255 - ta);
    ta255_next  = {ta, {CH_W{1'b0}}} - {{CH_W{1'b0}}, ta};
    for (int i = 0; i < LANES; i++) begin
      tcta_next[i] = fill_color[i*CH_W +: CH_W] * ta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_inside <= inside_next;
      b_dst    <= a_dst;
      b_ta255  <= ta255_next;
      b_wb     <= wb_next;
      b_tcta   <= tcta_next;
    end
  end

  // numerators and the shared denominator
  always_comb begin
    word_next.hit = b_inside;
    word_next.dst = b_dst;
    word_next.den = b_ta255 + b_wb;
    word_next.quo = '0;
    for (int i = 0; i < LANES; i++) begin
      word_next.rem[i] = ({b_tcta[i], {CH_W{1'b0}}} - {{CH_W{1'b0}}, b_tcta[i]})
                       + b_dst[i*CH_W +: CH_W] * b_wb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/rab_div_stage.sv
// one registered restoring division step, three colour lanes sharing a divisor
`default_nettype none
module rab_div_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  rab_pkg::div_word_t   in_word,
  output logic                 out_valid,
  output rab_pkg::div_word_t   out_word
);
  import rab_pkg::*;

  logic [NUM_W:0] den_sh;
  logic [NUM_W:0] trial;
  div_word_t      word_next;

  always_comb begin
    word_next = in_word;
    den_sh    = {{(NUM_W+1-DEN_W){1'b0}}, in_word.den} << SHIFT;
    trial     = '0;
    for (int i = 0; i < LANES; i++) begin
      trial = {1'b0, in_word.rem[i]} - den_sh;
      if (!trial[NUM_W]) begin
        word_next.rem[i]        = trial[NUM_W-1:0];
        word_next.quo[i][SHIFT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/rect_alpha_blend_fill.sv
// Rectangle fill with non-premultiplied "over" blending on ARGB8888 pixels.
// Input stream s_axis carries one pixel position and the destination pixel
// found there; output stream m_axis returns the pixel, blended with the fill
// colour when the position lies in the rectangle clipped to the frame, else
// unchanged, with tuser high for a blended pixel. One result per transfer,
// in order.
// Registers must be written via cfg_we / cfg_index / cfg_data with no pixel
// in flight, unchecked by the block; clipped bounds follow in the next cycle.
// From input transfer to output valid a pixel passes three stages for
// the rectangle test and the products, eight stages of a restoring divider
// (one quotient bit per stage, three colour lanes in parallel) and the output
// register. One pixel is accepted every cycle unless the output stalls.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults (colour and
// rectangle zero, frame 4096 by 4096); s_axis_tready is high after reset.
`default_nettype none
module rect_alpha_blend_fill #(
  parameter int unsigned MAX_FRAME_DIM = rab_pkg::MAX_FRAME_DIM_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pos_x [11:0], pos_y [23:12], dst_pixel [55:24]
  input  wire logic [rab_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // out_pixel [31:0]
  output logic      [rab_pkg::COLOR_W-1:0]      m_axis_tdata,
  // inside_rect [0]
  output logic                                  m_axis_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [rab_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rab_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rab_pkg::*;

  logic               en;
  logic [COLOR_W-1:0] fill_color;
  bounds_t            bounds;
  logic [QUO_W:0]     div_valid;
  div_word_t          div_word [QUO_W+1];
  div_word_t          last;
  logic               den_zero;
  logic [COLOR_W-1:0] blended;
  logic [COLOR_W-1:0] pixel_next;

  // a single stall signal freezes every stage
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  rab_cfg #(
    .MAX_FRAME_DIM (MAX_FRAME_DIM)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fill_color (fill_color),
    .bounds     (bounds)
  );

  rab_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_axis_tvalid),
    .pos_x      (s_axis_tdata[POS_W-1:0]),
    .pos_y      (s_axis_tdata[2*POS_W-1:POS_W]),
    .dst_pixel  (s_axis_tdata[2*POS_W +: COLOR_W]),
    .fill_color (fill_color),
    .bounds     (bounds),
    .out_valid  (div_valid[0]),
    .out_word   (div_word[0])
  );

  // quotient bits from the top down
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    rab_div_stage #(
      .SHIFT (QUO_W - 1 - k)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (div_valid[k]),
      .in_word   (div_word[k]),
      .out_valid (div_valid[k+1]),
      .out_word  (div_word[k+1])
    );
  end

  always_comb begin
    last     = div_word[QUO_W];
    den_zero = (last.den == '0);
    blended[COLOR_W-1 -: CH_W] = div255(last.den);
    for (int i = 0; i < LANES; i++) begin
      blended[i*CH_W +: CH_W] = den_zero ? '0 : last.quo[i];
    end
    pixel_next = last.hit ? blended : last.dst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= div_valid[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= pixel_next;
      m_axis_tuser <= last.hit;
    end
  end

endmodule
`default_nettype wire

// File: hdl/rab_checker.sv
// port-level checks for the rectangle alpha blend fill, bound to the top level
`default_nettype none
module rab_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [rab_pkg::COLOR_W-1:0]      m_axis_tdata,
  input wire logic                             m_axis_tuser
);

  // nothing left over from before reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // a waiting result is held until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output changed");

  // a stalled output holds the pipeline, so no transfer may enter
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  // with the output register empty the pipeline always moves
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

endmodule

bind rect_alpha_blend_fill rab_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
